### hdl/fmdcs_pkg.sv
// ----------------------------------------------------------------------------
// fmdcs_pkg
// Shared types and constants for the distinct-count sketch core.
// ----------------------------------------------------------------------------
package fmdcs_pkg;

  // action codes of an input transaction
  typedef enum logic [1:0] {
    ACT_INSERT = 2'd0,
    ACT_QUERY  = 2'd1,
    ACT_CLEAR  = 2'd2,
    ACT_NONE   = 2'd3
  } action_t;

  // configuration register indexes
  localparam logic CFG_BITMAP_COUNT  = 1'b0;
  localparam logic CFG_BITMAP_LENGTH = 1'b1;

  // configuration widths and reset values
  localparam int unsigned CNT_W = 9;
  localparam int unsigned LEN_W = 7;
  localparam int unsigned SUM_W = 15;
  localparam logic [CNT_W-1:0] CNT_RESET = 9'd64;
  localparam logic [LEN_W-1:0] LEN_RESET = 7'd32;

  // controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_RD,
    ST_WR,
    ST_CLR,
    ST_Q_RD,
    ST_Q_TAIL,
    ST_Q_OUT
  } state_t;

  // commands from controller to datapath
  typedef struct packed {
    logic load;
    logic div_step;
    logic rd_bucket;
    logic wr_bucket;
    logic walk_step;
    logic clear_all;
    logic out_load;
  } cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic div_done;
    logic walk_last;
    logic out_free;
  } status_t;

  // position of lowest set bit, 64 when the word is zero
  function automatic logic [6:0] lowest_set64(input logic [63:0] v);
    logic [6:0] r;
    r = 7'd64;
    for (int i = 63; i >= 0; i--) begin
      if (v[i]) r = 7'(i);
    end
    return r;
  endfunction

endpackage

### hdl/fm_distinct_count_sketch_core.sv
// Insert: accepted, then the bucket modulo, a store read and a
//   write; the next transaction is taken once the write is done.
// Query: one store read per bitmap in use; the result is loaded into the
//   output register once it is free, and the next transaction follows.
// Clear: a single state. Reset: bitmap_count 64, bitmap_length 32; per-entry
//   valid bits clear the store at once, so no clearing pass is needed.
// ----------------------------------------------------------------------------
// fm_distinct_count_sketch_core
// Flajolet-Martin (PCSA) distinct-count sketch over a host supplied digest.
// ----------------------------------------------------------------------------
module fm_distinct_count_sketch_core
  import fmdcs_pkg::*;
#(
  parameter int unsigned MAX_BITS    = 64,
  parameter int unsigned MAX_BITMAPS = 256
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [CNT_W-1:0]  cfg_wdata,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        in_action,
  input  logic [7:0]        in_bucket_byte,
  input  logic [63:0]       in_rank_bits,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [SUM_W-1:0]  out_rank_sum
);

  cmd_t    cmd;
  status_t status;

  // transaction sequencer
  fmdcs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_action (in_action),
    .in_stall  (in_stall),
    .status    (status),
    .cmd       (cmd)
  );

  // store and arithmetic
  fmdcs_dpath #(
    .MAX_BITS    (MAX_BITS),
    .MAX_BITMAPS (MAX_BITMAPS)
  ) u_dpath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_bucket_byte (in_bucket_byte),
    .in_rank_bits   (in_rank_bits),
    .cmd            (cmd),
    .status         (status),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_rank_sum   (out_rank_sum)
  );

endmodule

### hdl/fmdcs_ram.sv
// ----------------------------------------------------------------------------
// fmdcs_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module fmdcs_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 256,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

### hdl/fmdcs_ctrl.sv
// ----------------------------------------------------------------------------
// fmdcs_ctrl
// Sequencer for insert, query and clear transactions.
// ----------------------------------------------------------------------------
module fmdcs_ctrl
  import fmdcs_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic [1:0] in_action,
  output logic       in_stall,
  input  status_t    status,
  output cmd_t       cmd
);

  state_t state_r, state_nxt;
  action_t act;
  logic accept;

  assign act    = action_t'(in_action);
  assign accept = in_valid && (state_r == ST_IDLE);

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          unique case (act)
            ACT_INSERT: state_nxt = ST_DIV;
            ACT_QUERY:  state_nxt = ST_Q_RD;
            ACT_CLEAR:  state_nxt = ST_CLR;
            ACT_NONE:   state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_DIV:    if (status.div_done) state_nxt = ST_RD;
      ST_RD:     state_nxt = ST_WR;
      ST_WR:     state_nxt = ST_IDLE;
      ST_CLR:    state_nxt = ST_IDLE;
      ST_Q_RD:   if (status.walk_last) state_nxt = ST_Q_TAIL;
      ST_Q_TAIL: state_nxt = ST_Q_OUT;
      ST_Q_OUT:  if (status.out_free) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // command outputs
  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    unique case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        cmd.load = accept;
      end
      ST_DIV:    cmd.div_step  = 1'b1;
      ST_RD:     cmd.rd_bucket = 1'b1;
      ST_WR:     cmd.wr_bucket = 1'b1;
      ST_CLR:    cmd.clear_all = 1'b1;
      ST_Q_RD:   cmd.walk_step = 1'b1;
      ST_Q_TAIL: cmd = '0;
      ST_Q_OUT:  cmd.out_load  = status.out_free;
      default:   cmd = '0;
    endcase
  end

endmodule

### hdl/fmdcs_dpath.sv
// ----------------------------------------------------------------------------
// fmdcs_dpath
// Bitmap store, bucket modulo unit, rank logic, query accumulator and
// output register.
// ----------------------------------------------------------------------------
module fmdcs_dpath
  import fmdcs_pkg::*;
#(
  parameter int unsigned MAX_BITS    = 64,
  parameter int unsigned MAX_BITMAPS = 256
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [CNT_W-1:0]  cfg_wdata,
  input  logic [7:0]        in_bucket_byte,
  input  logic [63:0]       in_rank_bits,
  input  cmd_t              cmd,
  output status_t           status,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [SUM_W-1:0]  out_rank_sum
);

  localparam int unsigned AW = (MAX_BITMAPS > 1) ? $clog2(MAX_BITMAPS) : 1;
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_BITMAPS);
  localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_BITS);

  // configuration registers
  logic [CNT_W-1:0] cnt_r;
  logic [LEN_W-1:0] len_r;
  logic [CNT_W-1:0] cnt_use;
  logic [LEN_W-1:0] len_use;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= CNT_RESET;
      len_r <= LEN_RESET;
    end else if (cfg_we) begin
      if (cfg_index == CFG_BITMAP_COUNT)  cnt_r <= cfg_wdata;
      if (cfg_index == CFG_BITMAP_LENGTH) len_r <= cfg_wdata[LEN_W-1:0];
    end
  end

  // clamp registers to the supported range
  always_comb begin
    if (cnt_r == '0)         cnt_use = CNT_W'(1);
    else if (cnt_r > CNT_MAX) cnt_use = CNT_MAX;
    else                     cnt_use = cnt_r;
    if (len_r == '0)         len_use = LEN_W'(1);
    else if (len_r > LEN_MAX) len_use = LEN_MAX;
    else                     len_use = len_r;
  end

  // rank of the incoming digest, saturated to length minus one
  logic [LEN_W-1:0] rank_raw;
  logic [LEN_W-1:0] rank_sat;
  logic [LEN_W-1:0] rank_r;

  assign rank_raw = lowest_set64(in_rank_bits);
  assign rank_sat = (rank_raw >= len_use) ? (len_use - LEN_W'(1)) : rank_raw;

  // bucket modulo unit, two restoring steps per cycle
  logic [7:0]       quo_r;
  logic [CNT_W-1:0] rem_r;
  logic [1:0]       div_cnt_r;
  logic [CNT_W:0]   part1, part2;
  logic [CNT_W-1:0] rem1, rem2;

  always_comb begin
    part1 = {rem_r, quo_r[7]};
    if (part1 >= {1'b0, cnt_use}) part1 = part1 - {1'b0, cnt_use};
    rem1  = part1[CNT_W-1:0];
    part2 = {rem1, quo_r[6]};
    if (part2 >= {1'b0, cnt_use}) part2 = part2 - {1'b0, cnt_use};
    rem2  = part2[CNT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      quo_r  <= in_bucket_byte;
      rem_r  <= '0;
      rank_r <= rank_sat;
    end else if (cmd.div_step) begin
      quo_r <= {quo_r[5:0], 2'b00};
      rem_r <= rem2;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n)            div_cnt_r <= '0;
    else if (cmd.load)     div_cnt_r <= '0;
    else if (cmd.div_step) div_cnt_r <= div_cnt_r + 2'd1;
  end

  // query walk counter
  logic [CNT_W-1:0] walk_cnt_r;
  logic             walk_vld_r;

  always_ff @(posedge clk) begin
    if (cmd.load)           walk_cnt_r <= '0;
    else if (cmd.walk_step) walk_cnt_r <= walk_cnt_r + CNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) walk_vld_r <= 1'b0;
    else        walk_vld_r <= cmd.walk_step;
  end

  // bitmap store with per-entry valid bits, invalid entries read as zero
  logic [MAX_BITMAPS-1:0] vld_r;
  logic                   vld_q_r;
  logic [AW-1:0]          bucket_addr;
  logic [AW-1:0]          rd_addr;
  logic                   rd_en;
  logic [MAX_BITS-1:0]    ram_rdata;
  logic [MAX_BITS-1:0]    word;
  logic [MAX_BITS-1:0]    wr_word;

  assign bucket_addr = rem_r[AW-1:0];
  assign rd_en       = cmd.rd_bucket || cmd.walk_step;
  assign rd_addr     = cmd.walk_step ? walk_cnt_r[AW-1:0] : bucket_addr;
  assign word        = vld_q_r ? ram_rdata : '0;
  assign wr_word     = word | (MAX_BITS'(1) << rank_r);

  always_ff @(posedge clk) begin
    if (!rst_n)             vld_r <= '0;
    else if (cmd.clear_all) vld_r <= '0;
    else if (cmd.wr_bucket) vld_r[bucket_addr] <= 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rd_en) vld_q_r <= vld_r[rd_addr];
  end

  fmdcs_ram #(
    .WIDTH (MAX_BITS),
    .DEPTH (MAX_BITMAPS)
  ) u_store (
    .clk   (clk),
    .we    (cmd.wr_bucket),
    .waddr (bucket_addr),
    .wdata (wr_word),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (ram_rdata)
  );

  // leading run of ones of the word read back, capped at the length
  logic [63:0]      word_inv;
  logic [LEN_W-1:0] run_raw;
  logic [LEN_W-1:0] run;
  logic [SUM_W-1:0] sum_r;

  assign word_inv = ~(64'(word));
  assign run_raw  = lowest_set64(word_inv);
  assign run      = (run_raw > len_use) ? len_use : run_raw;

  always_ff @(posedge clk) begin
    if (cmd.load)        sum_r <= '0;
    else if (walk_vld_r) sum_r <= sum_r + SUM_W'(run);
  end

  // output register
  logic             out_valid_r;
  logic [SUM_W-1:0] out_sum_r;

  always_ff @(posedge clk) begin
    if (!rst_n)            out_valid_r <= 1'b0;
    else if (cmd.out_load) out_valid_r <= 1'b1;
    else if (!out_stall)   out_valid_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) out_sum_r <= sum_r;
  end

  assign out_valid    = out_valid_r;
  assign out_rank_sum = out_sum_r;

  // status to the controller
  assign status.div_done  = (div_cnt_r == 2'd3);
  assign status.walk_last = (walk_cnt_r == (cnt_use - CNT_W'(1)));
  assign status.out_free  = !out_valid_r || !out_stall;

endmodule

### tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking testbench for fm_distinct_count_sketch_core. Drives insert,
// query, clear and unused transactions under random idling and stalls, keeps
// a mirror of the bitmap store and registers, and checks every rank sum.
// ----------------------------------------------------------------------------
module tb;
  import fmdcs_pkg::*;

  localparam int unsigned CYCLE_LIMIT   = 1000000;
  localparam int unsigned SETTLE_CYCLES = 16;
  localparam int unsigned MAX_WAIT      = 12;
  localparam int unsigned REPORT_LIMIT  = 10;
  localparam int unsigned STORE_DEPTH   = 256;
  localparam int unsigned WORD_BITS     = 64;

  logic             clk;
  logic             rst_n;
  logic             cfg_we;
  logic             cfg_index;
  logic [CNT_W-1:0] cfg_wdata;
  logic             in_valid;
  logic             in_stall;
  logic [1:0]       in_action;
  logic [7:0]       in_bucket_byte;
  logic [63:0]      in_rank_bits;
  logic             out_valid;
  logic             out_stall;
  logic [SUM_W-1:0] out_rank_sum;

  // mirror of the sketch state
  logic [63:0]      sketch_words [STORE_DEPTH];
  logic [CNT_W-1:0] mirror_count;
  logic [LEN_W-1:0] mirror_length;
  logic [SUM_W-1:0] sums_due [$];

  int unsigned error_count;
  logic        no_idle;

  fm_distinct_count_sketch_core dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_action      (in_action),
    .in_bucket_byte (in_bucket_byte),
    .in_rank_bits   (in_rank_bits),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_rank_sum   (out_rank_sum)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // run limit
  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("tb: done, errors");
    $finish;
  end

  function automatic int unsigned draw_wait();
    if (no_idle) return 0;
    return $urandom_range(MAX_WAIT, 0);
  endfunction

  function automatic logic [63:0] rand_word();
    return {$urandom(), $urandom()};
  endfunction

  // effective register values after clamping
  function automatic int unsigned count_in_use();
    if (mirror_count == 0) return 1;
    if (mirror_count > STORE_DEPTH) return STORE_DEPTH;
    return 32'(mirror_count);
  endfunction

  function automatic int unsigned length_in_use();
    if (mirror_length == 0) return 1;
    if (mirror_length > WORD_BITS) return WORD_BITS;
    return 32'(mirror_length);
  endfunction

  // lowest set bit, all zero counts as 64
  function automatic int unsigned rank_of(input logic [63:0] bits);
    for (int i = 0; i < WORD_BITS; i++) begin
      if (bits[i]) return i;
    end
    return WORD_BITS;
  endfunction

  // update the mirror for one accepted transaction
  function automatic void apply_item(input action_t act, input logic [7:0] bucket,
                                     input logic [63:0] bits);
    int unsigned cnt;
    int unsigned len;
    int unsigned r;
    int unsigned run;
    int unsigned total;
    cnt = count_in_use();
    len = length_in_use();
    case (act)
      ACT_INSERT: begin
        r = rank_of(bits);
        if (r >= len) r = len - 1;
        sketch_words[bucket % cnt][r] = 1'b1;
      end
      ACT_QUERY: begin
        total = 0;
        for (int b = 0; b < cnt; b++) begin
          run = 0;
          while (run < len && sketch_words[b][run]) run++;
          total += run;
        end
        sums_due = {sums_due, SUM_W'(total)};
      end
      ACT_CLEAR: begin
        for (int b = 0; b < STORE_DEPTH; b++) sketch_words[b] = '0;
      end
      default: ;
    endcase
  endfunction

  // send one transaction, called and returning at a falling edge
  task automatic send_item(input action_t act, input logic [7:0] bucket,
                           input logic [63:0] bits);
    int unsigned gap;
    gap = draw_wait();
    if (gap != 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_action      = act;
    in_bucket_byte = bucket;
    in_rank_bits   = bits;
    in_valid       = 1'b1;
    do @(posedge clk); while (in_stall);
    apply_item(act, bucket, bits);
    @(negedge clk);
  endtask

  // let every pending result arrive and the last insert finish
  task automatic wait_idle();
    in_valid = 1'b0;
    while (sums_due.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [CNT_W-1:0] value);
    wait_idle();
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_wdata = value;
    @(negedge clk);
    cfg_we = 1'b0;
    if (idx == CFG_BITMAP_COUNT) mirror_count = value;
    else mirror_length = value[LEN_W-1:0];
  endtask

  // digest bits: mostly natural geometric ranks, some shaped, some zero
  function automatic logic [63:0] pick_rank_bits();
    int unsigned sel;
    int unsigned r;
    sel = $urandom_range(15, 0);
    if (sel == 0) return '0;
    if (sel < 5) begin
      r = $urandom_range(WORD_BITS - 1, 0);
      return (rand_word() << r) | (64'd1 << r);
    end
    return rand_word();
  endfunction

  // random mix of transactions, inserts dominate
  task automatic run_batch(input int unsigned n);
    int unsigned sel;
    for (int unsigned i = 0; i < n; i++) begin
      sel = $urandom_range(119, 0);
      if (sel < 12) send_item(ACT_QUERY, 8'($urandom_range(255, 0)), rand_word());
      else if (sel < 14) send_item(ACT_CLEAR, 8'($urandom_range(255, 0)), rand_word());
      else if (sel < 17) send_item(ACT_NONE, 8'($urandom_range(255, 0)), rand_word());
      else send_item(ACT_INSERT, 8'($urandom_range(255, 0)), pick_rank_bits());
    end
    send_item(ACT_QUERY, 8'($urandom_range(255, 0)), rand_word());
  endtask

  // result side: random stalls, then compare against the oldest pending sum
  initial begin : result_check
    int unsigned hold;
    logic        seen;
    logic [SUM_W-1:0] want;
    out_stall = 1'b0;
    @(negedge clk);
    forever begin
      hold = draw_wait();
      out_stall = (hold != 0);
      forever begin
        @(posedge clk);
        if (out_valid && !out_stall) break;
        seen = out_valid;
        @(negedge clk);
        if (seen && hold > 0) begin
          hold--;
          if (hold == 0) out_stall = 1'b0;
        end
      end
      if (sums_due.size() == 0) begin
        error_count++;
        if (error_count <= REPORT_LIMIT)
          $display("tb: unexpected rank sum %0d", out_rank_sum);
      end else begin
        want = sums_due.pop_front();
        if (out_rank_sum !== want) begin
          error_count++;
          if (error_count <= REPORT_LIMIT)
            $display("tb: rank sum mismatch, expected %0d, got %0d", want, out_rank_sum);
        end
      end
      @(negedge clk);
    end
  end

  // directed corner cases at reset configuration
  task automatic test_directed();
    no_idle = 1'b0;
    send_item(ACT_QUERY, 8'd0, 64'd0);
    send_item(ACT_INSERT, 8'd0, 64'd1);
    send_item(ACT_INSERT, 8'd64, 64'd2);
    send_item(ACT_INSERT, 8'd255, 64'd0);
    send_item(ACT_INSERT, 8'd128, 64'h8000_0000_0000_0000);
    send_item(ACT_INSERT, 8'd1, '1);
    send_item(ACT_INSERT, 8'd0, 64'd4);
    send_item(ACT_QUERY, 8'd255, '1);
    send_item(ACT_NONE, 8'd0, 64'd1);
    send_item(ACT_NONE, 8'd255, '1);
    send_item(ACT_INSERT, 8'd0, 64'h8);
    send_item(ACT_INSERT, 8'd200, 64'h8000_0000);
    send_item(ACT_QUERY, 8'd17, 64'd0);
    send_item(ACT_CLEAR, 8'd255, '1);
    send_item(ACT_QUERY, 8'd0, 64'd0);
    send_item(ACT_INSERT, 8'd63, 64'h5555_5555_5555_5555);
    send_item(ACT_INSERT, 8'd127, 64'hAAAA_AAAA_AAAA_AAAA);
    send_item(ACT_QUERY, 8'd0, 64'd0);
  endtask

  // one phase at given register values, store kept from before
  task automatic run_setting(input logic [CNT_W-1:0] cnt, input logic [CNT_W-1:0] len,
                             input int unsigned n);
    write_reg(CFG_BITMAP_COUNT, cnt);
    write_reg(CFG_BITMAP_LENGTH, len);
    send_item(ACT_QUERY, 8'($urandom_range(255, 0)), rand_word());
    run_batch(n);
  endtask

  // register extremes and out of range values
  task automatic test_register_extremes();
    no_idle = 1'b1;
    run_setting(9'd0, 9'd0, 25);
    no_idle = 1'b0;
    run_setting(9'd1, 9'd1, 25);
    run_setting(9'd511, 9'd127, 25);
    run_setting(9'd256, 9'd64, 25);
    run_setting(9'd257, 9'd65, 25);
    run_setting(9'd2, 9'd63, 25);
    run_setting(9'd1, 9'h1C5, 25);
    run_setting(9'd3, 9'd64, 25);
  endtask

  // random settings, mostly few bitmaps so runs grow
  task automatic test_random_settings();
    int unsigned sel;
    logic [CNT_W-1:0] cnt;
    logic [CNT_W-1:0] len;
    for (int p = 0; p < 11; p++) begin
      no_idle = ($urandom_range(3, 0) == 0);
      sel = $urandom_range(9, 0);
      if (sel < 7) cnt = CNT_W'($urandom_range(16, 1));
      else if (sel < 9) cnt = CNT_W'($urandom_range(255, 17));
      else cnt = CNT_W'($urandom_range(511, 256));
      case ($urandom_range(3, 0))
        0: len = CNT_W'($urandom_range(8, 1));
        1: len = CNT_W'($urandom_range(64, 1));
        2: len = CNT_W'($urandom_range(511, 0));
        default: len = CNT_W'($urandom_range(3, 1));
      endcase
      if ($urandom_range(2, 0) == 0)
        send_item(ACT_CLEAR, 8'($urandom_range(255, 0)), rand_word());
      run_setting(cnt, len, 126);
    end
  endtask

  // reset and test sequence
  initial begin
    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_index      = CFG_BITMAP_COUNT;
    cfg_wdata      = '0;
    in_valid       = 1'b0;
    in_action      = ACT_NONE;
    in_bucket_byte = '0;
    in_rank_bits   = '0;
    no_idle        = 1'b0;
    error_count    = 0;
    mirror_count   = CNT_RESET;
    mirror_length  = LEN_RESET;
    for (int b = 0; b < STORE_DEPTH; b++) sketch_words[b] = '0;
    repeat (9) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    test_directed();
    test_register_extremes();
    test_random_settings();

    wait_idle();
    if (error_count == 0) $display("tb: done, clean");
    else $display("tb: done, errors");
    $finish;
  end

endmodule
